@@ hw/rtl/tdbl_pkg.sv @@
// Shared constants and types for the tree distance engine.
package tdbl_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int DIST_W  = 11;
  localparam int LVL_W   = 5;
  localparam int REQ_W   = 2;

  localparam int DEF_MAX_NODES   = 1024;
  localparam int DEF_JUMP_LEVELS = 10;

  localparam logic [NODE_W-1:0]  NODE_COUNT_RST = NODE_W'(1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX      = '1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  // store access issued by the sequencer, read data back in the following cycle
  typedef struct packed {
    logic               depth_we;
    logic [NODE_W-1:0]  depth_wnode;
    logic [DEPTH_W-1:0] depth_wdata;
    logic [NODE_W-1:0]  depth_rnode;
    logic               jump_we;
    logic [NODE_W-1:0]  jump_wnode;
    logic [LVL_W-1:0]   jump_wlvl;
    logic [NODE_W-1:0]  jump_wdata;
    logic [NODE_W-1:0]  jump_rnode_a;
    logic [LVL_W-1:0]   jump_rlvl_a;
    logic [NODE_W-1:0]  jump_rnode_b;
    logic [LVL_W-1:0]   jump_rlvl_b;
  } store_req_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_rdata;
    logic [NODE_W-1:0]  jump_rdata_a;
    logic [NODE_W-1:0]  jump_rdata_b;
  } store_rsp_t;

  typedef struct packed {
    logic              answer_valid;
    logic [NODE_W-1:0] common_ancestor;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage

@@ hw/rtl/tdbl_if.sv @@
// Valid/ready channel interfaces for request and result words.
interface tdbl_in_if;
  logic                         valid;
  logic                         ready;
  logic [tdbl_pkg::REQ_W-1:0]   req_type;
  logic [tdbl_pkg::NODE_W-1:0]  node_a;
  logic [tdbl_pkg::NODE_W-1:0]  node_b;

  modport source (output valid, req_type, node_a, node_b, input ready);
  modport sink   (input valid, req_type, node_a, node_b, output ready);
endinterface

interface tdbl_out_if;
  logic                         valid;
  logic                         ready;
  logic                         answer_valid;
  logic [tdbl_pkg::NODE_W-1:0]  common_ancestor;
  logic [tdbl_pkg::DIST_W-1:0]  distance;

  modport source (output valid, answer_valid, common_ancestor, distance, input ready);
  modport sink   (input valid, answer_valid, common_ancestor, distance, output ready);
endinterface

@@ hw/rtl/tree_distance_binary_lifting_top.sv @@
// Top level of the tree distance engine: channels, config register, result register.
//
// Usage notes:
// - in_ch carries request words: req_type (load / build / query), node_a, node_b.
//   A load stores node_b as parent of node_a; parents go in before children.
//   Build fills the jump table; run it after all loads and before queries.
// - out_ch returns one word per request: a query answer (answer_valid = 1,
//   common ancestor and distance) or an acknowledgment of zeros.
// - cfg_we / cfg_wdata write node_count, which sets the build range. Write only
//   while the engine is idle.
// - One request at a time: in_ch.ready drops on acceptance and returns once the
//   result sits in the output register, so a new word can be taken while the
//   previous result still waits for the receiver.
// - Time from acceptance to out_ch.valid depends on the request code; for a query
//   also on JUMP_LEVELS, on the depth gap and on whether the lifted node already
//   is the other one, for a build on JUMP_LEVELS and min(node_count, MAX_NODES - 1).
//   The memory reads are registered.
// - Reset clears control and sets node_count to 1; memory contents stay
//   undefined until loaded, except node 0 which always reads as zero.
// - A stalled receiver holds the output register; the engine then waits with
//   its next result and takes no new request.
module tree_distance_binary_lifting_top #(
  parameter int MAX_NODES   = tdbl_pkg::DEF_MAX_NODES,
  parameter int JUMP_LEVELS = tdbl_pkg::DEF_JUMP_LEVELS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tdbl_in_if.sink                      in_ch,
  tdbl_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [tdbl_pkg::NODE_W-1:0]  cfg_wdata
);

  logic [tdbl_pkg::NODE_W-1:0] node_count_r;
  logic                        out_valid_r, out_valid_nxt;
  tdbl_pkg::res_t              out_res_r;

  logic                        seq_idle;
  logic                        seq_res_valid;
  tdbl_pkg::res_t              seq_res;
  logic                        res_take;
  logic                        start;
  tdbl_pkg::store_req_t        store_req;
  tdbl_pkg::store_rsp_t        store_rsp;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= tdbl_pkg::NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = seq_idle;
  assign start       = in_ch.valid && in_ch.ready;

  // result moves on when the output register is empty or draining
  assign res_take      = seq_res_valid && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = res_take ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_take) begin
      out_res_r <= seq_res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.answer_valid    = out_res_r.answer_valid;
  assign out_ch.common_ancestor = out_res_r.common_ancestor;
  assign out_ch.distance        = out_res_r.distance;

  tdbl_seq #(
    .MAX_NODES   (MAX_NODES),
    .JUMP_LEVELS (JUMP_LEVELS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req_type   (in_ch.req_type),
    .node_a     (in_ch.node_a),
    .node_b     (in_ch.node_b),
    .node_count (node_count_r),
    .idle       (seq_idle),
    .res_valid  (seq_res_valid),
    .res        (seq_res),
    .res_take   (res_take),
    .store_req  (store_req),
    .store_rsp  (store_rsp)
  );

  tdbl_store #(
    .MAX_NODES   (MAX_NODES),
    .JUMP_LEVELS (JUMP_LEVELS)
  ) u_store (
    .clk (clk),
    .req (store_req),
    .rsp (store_rsp)
  );

  // one request in flight: accepting a word closes the input next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ch.ready)
    else $error("request accepted while previous one still in progress");

  // acknowledgments carry zeros
  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.answer_valid) |->
      (out_ch.common_ancestor == '0 && out_ch.distance == '0))
    else $error("acknowledgment word with non-zero payload");

  // node 0 is never written
  a_no_root_write: assert property (@(posedge clk) disable iff (!rst_n)
    (store_req.depth_we || store_req.jump_we) |->
      (store_req.depth_wnode != '0 || !store_req.depth_we) &&
      (store_req.jump_wnode != '0 || !store_req.jump_we))
    else $error("write to node 0");

  // a result only leaves the sequencer while the engine is busy
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |-> !seq_idle)
    else $error("result taken while sequencer idle");

endmodule

@@ hw/rtl/tdbl_store.sv @@
// Depth and ancestor-jump memories with registered reads; node 0 reads as zero.
module tdbl_store #(
  parameter int MAX_NODES   = tdbl_pkg::DEF_MAX_NODES,
  parameter int JUMP_LEVELS = tdbl_pkg::DEF_JUMP_LEVELS
) (
  input  logic                  clk,
  input  tdbl_pkg::store_req_t  req,
  output tdbl_pkg::store_rsp_t  rsp
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int AW = $clog2(JUMP_LEVELS * MAX_NODES);

  logic [tdbl_pkg::DEPTH_W-1:0] depth_mem [MAX_NODES];
  logic [tdbl_pkg::NODE_W-1:0]  jump_mem  [JUMP_LEVELS * MAX_NODES];

  logic [tdbl_pkg::DEPTH_W-1:0] depth_rd_r;
  logic [tdbl_pkg::NODE_W-1:0]  jump_rd_a_r;
  logic [tdbl_pkg::NODE_W-1:0]  jump_rd_b_r;
  logic                         depth_zero_r;
  logic                         jump_zero_a_r;
  logic                         jump_zero_b_r;

  // level-major layout
  function automatic logic [AW-1:0] jump_addr(input logic [tdbl_pkg::NODE_W-1:0] node,
                                              input logic [tdbl_pkg::LVL_W-1:0]  lvl);
    jump_addr = AW'(lvl) * AW'(MAX_NODES) + AW'(node);
  endfunction

  always_ff @(posedge clk) begin
    if (req.depth_we) begin
      depth_mem[NW'(req.depth_wnode)] <= req.depth_wdata;
    end
    depth_rd_r   <= depth_mem[NW'(req.depth_rnode)];
    depth_zero_r <= (req.depth_rnode == '0);
  end

  always_ff @(posedge clk) begin
    if (req.jump_we) begin
      jump_mem[jump_addr(req.jump_wnode, req.jump_wlvl)] <= req.jump_wdata;
    end
    jump_rd_a_r   <= jump_mem[jump_addr(req.jump_rnode_a, req.jump_rlvl_a)];
    jump_rd_b_r   <= jump_mem[jump_addr(req.jump_rnode_b, req.jump_rlvl_b)];
    jump_zero_a_r <= (req.jump_rnode_a == '0);
    jump_zero_b_r <= (req.jump_rnode_b == '0);
  end

  assign rsp.depth_rdata  = depth_zero_r  ? '0 : depth_rd_r;
  assign rsp.jump_rdata_a = jump_zero_a_r ? '0 : jump_rd_a_r;
  assign rsp.jump_rdata_b = jump_zero_b_r ? '0 : jump_rd_b_r;

endmodule

@@ hw/rtl/tdbl_seq.sv @@
// Sequencer for load, table build and lifting query over the shared store.
module tdbl_seq #(
  parameter int MAX_NODES   = tdbl_pkg::DEF_MAX_NODES,
  parameter int JUMP_LEVELS = tdbl_pkg::DEF_JUMP_LEVELS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tdbl_pkg::REQ_W-1:0]    req_type,
  input  logic [tdbl_pkg::NODE_W-1:0]   node_a,
  input  logic [tdbl_pkg::NODE_W-1:0]   node_b,
  input  logic [tdbl_pkg::NODE_W-1:0]   node_count,
  output logic                          idle,
  output logic                          res_valid,
  output tdbl_pkg::res_t                res,
  input  logic                          res_take,
  output tdbl_pkg::store_req_t          store_req,
  input  tdbl_pkg::store_rsp_t          store_rsp
);

  localparam int NODE_W  = tdbl_pkg::NODE_W;
  localparam int DEPTH_W = tdbl_pkg::DEPTH_W;
  localparam int DIST_W  = tdbl_pkg::DIST_W;
  localparam int LVL_W   = tdbl_pkg::LVL_W;
  localparam int GAP_W   = ((JUMP_LEVELS > DEPTH_W) ? JUMP_LEVELS : DEPTH_W) + 1;
  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(JUMP_LEVELS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_LD_RD, S_LD_WR,
    S_BLD_INIT, S_BLD_RD1, S_BLD_RD2, S_BLD_WR,
    S_Q_RDX, S_Q_RDY, S_Q_SORT, S_Q_LIFT, S_Q_LIFT_WT, S_Q_CHK,
    S_Q_PAIR, S_Q_PAIR_WT, S_Q_PAR, S_Q_PAR_WT, S_Q_DEP, S_Q_DIST,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [NODE_W-1:0]    x_r, x_nxt;
  logic [NODE_W-1:0]    y_r, y_nxt;
  logic [NODE_W-1:0]    idx_r, idx_nxt;
  logic [NODE_W-1:0]    last_r, last_nxt;
  logic [NODE_W-1:0]    lca_r, lca_nxt;
  logic [LVL_W-1:0]     lvl_r, lvl_nxt;
  logic [DEPTH_W-1:0]   gap_r, gap_nxt;
  logic [DEPTH_W-1:0]   dx_r, dx_nxt;
  logic [DIST_W-1:0]    dsum_r, dsum_nxt;
  tdbl_pkg::res_t       res_r, res_nxt;

  logic [GAP_W-1:0]     pow;
  logic [GAP_W-1:0]     gap_ext;
  logic [DIST_W+1:0]    diff;
  logic [NODE_W-1:0]    last_c;
  logic                 load_ok;
  logic [DEPTH_W-1:0]   rd_depth;

  function automatic logic [NODE_W-1:0] clip_node(input logic [NODE_W-1:0] v);
    clip_node = (32'(v) < MAX_NODES) ? v : '0;
  endfunction

  assign pow      = GAP_W'(1) << lvl_r;
  assign gap_ext  = GAP_W'(gap_r);
  assign rd_depth = store_rsp.depth_rdata;
  assign diff     = (DIST_W + 2)'(dsum_r) - (DIST_W + 2)'({rd_depth, 1'b0});
  assign last_c   = (32'(node_count) > MAX_NODES - 1) ? NODE_W'(MAX_NODES - 1) : node_count;
  assign load_ok  = (node_a != '0) && (32'(node_a) < MAX_NODES) && (32'(node_b) < MAX_NODES);

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    lca_nxt   = lca_r;
    lvl_nxt   = lvl_r;
    gap_nxt   = gap_r;
    dx_nxt    = dx_r;
    dsum_nxt  = dsum_r;
    res_nxt   = res_r;

    store_req              = '0;
    store_req.depth_rnode  = x_r;
    store_req.jump_rnode_a = x_r;
    store_req.jump_rlvl_a  = lvl_r;
    store_req.jump_rnode_b = y_r;
    store_req.jump_rlvl_b  = lvl_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          x_nxt   = node_a;
          y_nxt   = node_b;
          res_nxt = '0;
          case (req_type)
            tdbl_pkg::REQ_LOAD:  state_nxt = load_ok ? S_LD_RD : S_DONE;
            tdbl_pkg::REQ_BUILD: state_nxt = S_BLD_INIT;
            tdbl_pkg::REQ_QUERY: begin
              x_nxt     = clip_node(node_a);
              y_nxt     = clip_node(node_b);
              state_nxt = S_Q_RDX;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_LD_RD: begin
        store_req.depth_rnode = y_r;
        state_nxt = S_LD_WR;
      end
      S_LD_WR: begin
        store_req.depth_we    = 1'b1;
        store_req.depth_wnode = x_r;
        if (y_r == '0) begin
          store_req.depth_wdata = '0;
        end else if (rd_depth == tdbl_pkg::DEPTH_MAX) begin
          store_req.depth_wdata = tdbl_pkg::DEPTH_MAX;
        end else begin
          store_req.depth_wdata = rd_depth + DEPTH_W'(1);
        end
        store_req.jump_we    = 1'b1;
        store_req.jump_wnode = x_r;
        store_req.jump_wlvl  = '0;
        store_req.jump_wdata = y_r;
        state_nxt = S_DONE;
      end
      S_BLD_INIT: begin
        idx_nxt   = NODE_W'(1);
        lvl_nxt   = LVL_W'(1);
        last_nxt  = last_c;
        state_nxt = (last_c == '0) ? S_DONE : S_BLD_RD1;
      end
      S_BLD_RD1: begin
        store_req.jump_rnode_a = idx_r;
        store_req.jump_rlvl_a  = lvl_r - LVL_W'(1);
        state_nxt = S_BLD_RD2;
      end
      S_BLD_RD2: begin
        store_req.jump_rnode_a = store_rsp.jump_rdata_a;
        store_req.jump_rlvl_a  = lvl_r - LVL_W'(1);
        state_nxt = S_BLD_WR;
      end
      S_BLD_WR: begin
        store_req.jump_we    = 1'b1;
        store_req.jump_wnode = idx_r;
        store_req.jump_wlvl  = lvl_r;
        store_req.jump_wdata = store_rsp.jump_rdata_a;
        if (idx_r == last_r) begin
          if (lvl_r == LVL_TOP) begin
            state_nxt = S_DONE;
          end else begin
            lvl_nxt   = lvl_r + LVL_W'(1);
            idx_nxt   = NODE_W'(1);
            state_nxt = S_BLD_RD1;
          end
        end else begin
          idx_nxt   = idx_r + NODE_W'(1);
          state_nxt = S_BLD_RD1;
        end
      end
      S_Q_RDX: begin
        state_nxt = S_Q_RDY;
      end
      S_Q_RDY: begin
        dx_nxt = rd_depth;
        store_req.depth_rnode = y_r;
        state_nxt = S_Q_SORT;
      end
      S_Q_SORT: begin
        dsum_nxt = DIST_W'(dx_r) + DIST_W'(rd_depth);
        if (dx_r < rd_depth) begin
          x_nxt   = y_r;
          y_nxt   = x_r;
          gap_nxt = rd_depth - dx_r;
        end else begin
          gap_nxt = dx_r - rd_depth;
        end
        lvl_nxt   = LVL_TOP;
        state_nxt = S_Q_LIFT;
      end
      S_Q_LIFT: begin
        if (gap_ext >= pow) begin
          state_nxt = S_Q_LIFT_WT;
        end else if (lvl_r == '0) begin
          state_nxt = S_Q_CHK;
        end else begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end
      S_Q_LIFT_WT: begin
        x_nxt   = store_rsp.jump_rdata_a;
        gap_nxt = DEPTH_W'(gap_ext - pow);
        if (lvl_r == '0) begin
          state_nxt = S_Q_CHK;
        end else begin
          lvl_nxt   = lvl_r - LVL_W'(1);
          state_nxt = S_Q_LIFT;
        end
      end
      S_Q_CHK: begin
        if (x_r == y_r) begin
          lca_nxt   = x_r;
          state_nxt = S_Q_DEP;
        end else begin
          lvl_nxt   = LVL_TOP;
          state_nxt = S_Q_PAIR;
        end
      end
      S_Q_PAIR: begin
        state_nxt = S_Q_PAIR_WT;
      end
      S_Q_PAIR_WT: begin
        if (store_rsp.jump_rdata_a != store_rsp.jump_rdata_b) begin
          x_nxt = store_rsp.jump_rdata_a;
          y_nxt = store_rsp.jump_rdata_b;
        end
        if (lvl_r == '0) begin
          state_nxt = S_Q_PAR;
        end else begin
          lvl_nxt   = lvl_r - LVL_W'(1);
          state_nxt = S_Q_PAIR;
        end
      end
      S_Q_PAR: begin
        store_req.jump_rlvl_a = '0;
        state_nxt = S_Q_PAR_WT;
      end
      S_Q_PAR_WT: begin
        lca_nxt   = store_rsp.jump_rdata_a;
        state_nxt = S_Q_DEP;
      end
      S_Q_DEP: begin
        store_req.depth_rnode = lca_r;
        state_nxt = S_Q_DIST;
      end
      S_Q_DIST: begin
        res_nxt.answer_valid    = 1'b1;
        res_nxt.common_ancestor = lca_r;
        res_nxt.distance        = diff[DIST_W+1] ? '0 : DIST_W'(diff);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
    lca_r  <= lca_nxt;
    lvl_r  <= lvl_nxt;
    gap_r  <= gap_nxt;
    dx_r   <= dx_nxt;
    dsum_r <= dsum_nxt;
    res_r  <= res_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

@@ tb/tree_distance_binary_lifting_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the tree distance engine: directed script, then random tree phases and a full-size chain.
module tree_distance_binary_lifting_top_tb;

  localparam int NODE_W  = tdbl_pkg::NODE_W;
  localparam int DEPTH_W = tdbl_pkg::DEPTH_W;
  localparam int DIST_W  = tdbl_pkg::DIST_W;
  localparam int REQ_W   = tdbl_pkg::REQ_W;

  localparam logic [REQ_W-1:0] REQ_LOAD  = tdbl_pkg::REQ_LOAD;
  localparam logic [REQ_W-1:0] REQ_BUILD = tdbl_pkg::REQ_BUILD;
  localparam logic [REQ_W-1:0] REQ_QUERY = tdbl_pkg::REQ_QUERY;

  typedef tdbl_pkg::res_t res_t;

  localparam int LEVELS      = tdbl_pkg::DEF_JUMP_LEVELS;
  localparam int NODES       = tdbl_pkg::DEF_MAX_NODES;
  localparam int LAST_NODE   = NODES - 1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int IDLE_PCT    = 31;

  // request code the block acknowledges and otherwise ignores
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam res_t ACK_WORD = '0;

  // One line of the directed script. A config line writes node_a into node_count.
  // Where typed is set, want is the word to see; otherwise the predictor decides.
  typedef struct packed {
    logic              is_cfg;
    logic [REQ_W-1:0]  req;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic              typed;
    res_t              want;
  } script_row_t;

  localparam int SCRIPT_ROWS = 25;

  script_row_t script [SCRIPT_ROWS] = '{
    // empty tree: node 0 against itself, then ignored words
    '{1'b0, REQ_QUERY,  10'd0,    10'd0,    1'b1, res_t'{1'b1, 10'd0, 11'd0}},
    '{1'b0, REQ_UNUSED, 10'd1023, 10'd1023, 1'b1, ACK_WORD},
    '{1'b0, REQ_LOAD,   10'd0,    10'd1023, 1'b1, ACK_WORD},
    '{1'b0, REQ_UNUSED, 10'd0,    10'd0,    1'b1, ACK_WORD},
    // lone root, built with the reset node_count of 1
    '{1'b0, REQ_LOAD,   10'd1,    10'd0,    1'b1, ACK_WORD},
    '{1'b0, REQ_BUILD,  10'd0,    10'd0,    1'b1, ACK_WORD},
    '{1'b0, REQ_QUERY,  10'd1,    10'd1,    1'b1, res_t'{1'b1, 10'd1, 11'd0}},
    '{1'b0, REQ_QUERY,  10'd1,    10'd0,    1'b0, ACK_WORD},
    // small tree: 1 - 2 - {3, 4}
    '{1'b1, REQ_LOAD,   10'd4,    10'd0,    1'b0, ACK_WORD},
    '{1'b0, REQ_LOAD,   10'd2,    10'd1,    1'b1, ACK_WORD},
    '{1'b0, REQ_LOAD,   10'd3,    10'd2,    1'b1, ACK_WORD},
    '{1'b0, REQ_LOAD,   10'd4,    10'd2,    1'b1, ACK_WORD},
    '{1'b0, REQ_BUILD,  10'd0,    10'd0,    1'b1, ACK_WORD},
    '{1'b0, REQ_QUERY,  10'd3,    10'd4,    1'b1, res_t'{1'b1, 10'd2, 11'd2}},
    '{1'b0, REQ_QUERY,  10'd4,    10'd1,    1'b1, res_t'{1'b1, 10'd1, 11'd2}},
    '{1'b0, REQ_QUERY,  10'd0,    10'd3,    1'b0, ACK_WORD},
    // node_count of 0: build touches nothing
    '{1'b1, REQ_LOAD,   10'd0,    10'd0,    1'b0, ACK_WORD},
    '{1'b0, REQ_BUILD,  10'd0,    10'd0,    1'b1, ACK_WORD},
    '{1'b0, REQ_QUERY,  10'd3,    10'd3,    1'b1, res_t'{1'b1, 10'd3, 11'd0}},
    // top node index, a second root, then a self-parent loop
    '{1'b0, REQ_LOAD,   10'd1023, 10'd1,    1'b1, ACK_WORD},
    '{1'b0, REQ_LOAD,   10'd2,    10'd0,    1'b1, ACK_WORD},
    '{1'b0, REQ_QUERY,  10'd3,    10'd4,    1'b0, ACK_WORD},
    '{1'b0, REQ_LOAD,   10'd3,    10'd3,    1'b1, ACK_WORD},
    '{1'b0, REQ_QUERY,  10'd3,    10'd4,    1'b0, ACK_WORD},
    '{1'b0, REQ_QUERY,  10'd4,    10'd2,    1'b0, ACK_WORD}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [NODE_W-1:0]   cfg_wdata;

  tdbl_in_if  req_ch ();
  tdbl_out_if res_ch ();

  tree_distance_binary_lifting_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Tree shadow: depths, ancestor jumps and node_count as the block should hold them
  // ---------------------------------------------------------------------------
  logic [DEPTH_W-1:0] depth_mem [NODES];
  logic [NODE_W-1:0]  jump_mem  [NODES][LEVELS];
  logic [NODE_W-1:0]  node_count_shadow;
  int                 built_max;     // highest node whose upper jump levels were ever built

  res_t words_due [$];               // expected result words, oldest first
  int   work_count;                  // accepted words that do real work
  int   results_seen;
  int   mismatches;
  int   cycles;

  function automatic void rebuild_jumps();
    int last;
    last = (node_count_shadow > LAST_NODE) ? LAST_NODE : int'(node_count_shadow);
    for (int k = 1; k < LEVELS; k++)
      for (int i = 1; i <= last; i++)
        jump_mem[i][k] = jump_mem[jump_mem[i][k-1]][k-1];
    if (last > built_max) built_max = last;
  endfunction

  // lift the deeper node to the other's depth, then both together
  function automatic logic [NODE_W-1:0] common_root(logic [NODE_W-1:0] p, logic [NODE_W-1:0] q);
    logic [NODE_W-1:0] x, y, t;
    int gap;
    x = p;
    y = q;
    if (depth_mem[x] < depth_mem[y]) begin
      t = x; x = y; y = t;
    end
    gap = int'(depth_mem[x]) - int'(depth_mem[y]);
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (gap >= (1 << k)) begin
        x = jump_mem[x][k];
        gap -= (1 << k);
      end
    end
    if (x == y) return x;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (jump_mem[x][k] != jump_mem[y][k]) begin
        x = jump_mem[x][k];
        y = jump_mem[y][k];
      end
    end
    return jump_mem[x][0];
  endfunction

  // applies one accepted word to the shadow and returns the word it should produce
  function automatic res_t predict_word(logic [REQ_W-1:0] req, logic [NODE_W-1:0] a,
                                        logic [NODE_W-1:0] b);
    res_t              r;
    logic [NODE_W-1:0] lca;
    int                span;
    r = ACK_WORD;
    case (req)
      REQ_LOAD: begin
        if (a != 0) begin
          if (b == 0) depth_mem[a] = '0;
          else if (depth_mem[b] == tdbl_pkg::DEPTH_MAX) depth_mem[a] = tdbl_pkg::DEPTH_MAX;
          else depth_mem[a] = depth_mem[b] + DEPTH_W'(1);
          jump_mem[a][0] = b;
        end
      end
      REQ_BUILD: rebuild_jumps();
      REQ_QUERY: begin
        lca  = common_root(a, b);
        span = int'(depth_mem[a]) + int'(depth_mem[b]) - 2 * int'(depth_mem[lca]);
        if (span < 0) span = 0;
        if (span > 2047) span = 2047;
        r.answer_valid    = 1'b1;
        r.common_ancestor = lca;
        r.distance        = DIST_W'(span);
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("%0t: run stuck, %0d words still due", $time, words_due.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offers one word and returns at the edge that takes it; valid is left high so
  // a following word can go out back to back. Random idle cycles go in front,
  // except in the steady stretch.
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input logic typed = 1'b0,
                           input res_t want = '0);
    res_t guess;
    if (!(work_count >= 700 && work_count < 1000)) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= req;
    req_ch.node_a   <= a;
    req_ch.node_b   <= b;
    do @(posedge clk); while (!req_ch.ready);
    guess = predict_word(req, a, b);
    words_due.insert(words_due.size(), typed ? want : guess);
    if (!(req == REQ_UNUSED || (req == REQ_LOAD && a == 0))) work_count++;
  endtask

  // node_count may only change with the engine idle: every word answered
  task automatic write_node_count(input logic [NODE_W-1:0] v);
    req_ch.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count_shadow = v;
  endtask

  // a word the block acks and drops: unused code, or a load aimed at node 0
  task automatic send_noise();
    if ($urandom_range(1)) send_word(REQ_UNUSED, NODE_W'($urandom_range(LAST_NODE)),
                                     NODE_W'($urandom_range(LAST_NODE)));
    else send_word(REQ_LOAD, 10'd0, NODE_W'($urandom_range(LAST_NODE)));
  endtask

  task automatic send_queries(input int top, input int count);
    logic [NODE_W-1:0] x, y;
    for (int i = 0; i < count; i++) begin
      x = NODE_W'($urandom_range(top));
      y = ($urandom_range(9) == 0) ? x : NODE_W'($urandom_range(top));
      send_word(REQ_QUERY, x, y);
    end
  endtask

  // A fresh random tree over nodes 1..n, loaded in shuffled order with every
  // parent loaded first, then built and queried. Some phases query on the old
  // jump levels first, or reparent a few nodes (loops included) afterwards.
  task automatic run_tree_phase();
    int n, j, tmp, par;
    int order [$];
    int placed [$];
    n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 60);
    write_node_count(NODE_W'(n));
    for (int i = 1; i <= n; i++) order.insert(order.size(), i);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    foreach (order[i]) begin
      if ($urandom_range(19) == 0) send_noise();
      par = (placed.size() == 0 || $urandom_range(15) == 0) ? 0 :
            placed[$urandom_range(placed.size() - 1)];
      send_word(REQ_LOAD, NODE_W'(order[i]), NODE_W'(par));
      placed.insert(placed.size(), order[i]);
    end
    // upper levels still from an earlier build: only where all of them exist
    if (n <= built_max && $urandom_range(4) == 0) send_queries(n, 3);
    send_word(REQ_BUILD, NODE_W'($urandom_range(LAST_NODE)), NODE_W'($urandom_range(LAST_NODE)));
    send_queries(n, $urandom_range(8, 30));
    if ($urandom_range(9) < 3) begin
      repeat ($urandom_range(1, 3))
        send_word(REQ_LOAD, NODE_W'($urandom_range(1, n)), NODE_W'($urandom_range(n)));
      send_queries(n, 5);
      if ($urandom_range(1)) begin
        send_word(REQ_BUILD, 10'd0, 10'd0);
        send_queries(n, 5);
      end
    end
  endtask

  // Full-size chain 1..1023 for the deepest lifts, then the root hung under the
  // tail so depths saturate, rebuilt and queried again.
  task automatic run_deep_chain();
    write_node_count(NODE_W'(LAST_NODE));
    send_word(REQ_LOAD, 10'd1, 10'd0);
    for (int k = 2; k <= LAST_NODE; k++) send_word(REQ_LOAD, NODE_W'(k), NODE_W'(k - 1));
    send_word(REQ_BUILD, 10'd0, 10'd0);
    send_queries(LAST_NODE, 30);
    send_word(REQ_LOAD, 10'd1, NODE_W'(LAST_NODE));
    send_word(REQ_LOAD, 10'd2, 10'd1);
    repeat (3) send_word(REQ_LOAD, NODE_W'($urandom_range(4, LAST_NODE)), 10'd2);
    send_word(REQ_BUILD, 10'd0, 10'd0);
    send_queries(LAST_NODE, 20);
  endtask

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_LOAD;
    req_ch.node_a   = '0;
    req_ch.node_b   = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    work_count      = 0;
    built_max       = 0;
    node_count_shadow = tdbl_pkg::NODE_COUNT_RST;
    for (int i = 0; i < NODES; i++) begin
      depth_mem[i] = '0;
      for (int k = 0; k < LEVELS; k++) jump_mem[i][k] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (script[r].is_cfg) write_node_count(script[r].a);
      else send_word(script[r].req, script[r].a, script[r].b, script[r].typed, script[r].want);
    end

    while (work_count < 450) run_tree_phase();
    run_deep_chain();
    while (work_count < 1600) run_tree_phase();

    req_ch.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (words_due.size() != 0) mismatches++;
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, one steady stretch, one long hold-off so the
  // engine fills its output register and stops taking words
  // ---------------------------------------------------------------------------
  initial begin
    res_t want;
    int   hold_left;
    logic held_once;
    res_ch.ready = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (words_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: expected none, got %0d/%0d/%0d", $time,
                   res_ch.answer_valid, res_ch.common_ancestor, res_ch.distance);
        end else begin
          want = words_due.pop_front();
          if (res_ch.answer_valid !== want.answer_valid) begin
            mismatches++;
            $display("%0t: answer_valid: expected %0d, got %0d", $time,
                     want.answer_valid, res_ch.answer_valid);
          end
          if (res_ch.common_ancestor !== want.common_ancestor) begin
            mismatches++;
            $display("%0t: common_ancestor: expected %0d, got %0d", $time,
                     want.common_ancestor, res_ch.common_ancestor);
          end
          if (res_ch.distance !== want.distance) begin
            mismatches++;
            $display("%0t: distance: expected %0d, got %0d", $time,
                     want.distance, res_ch.distance);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (!held_once && results_seen >= 300 && req_ch.valid) begin
        // sender is offering: hold off long enough to back the engine up
        held_once = 1'b1;
        hold_left = 400;
        res_ch.ready <= 1'b0;
      end else if (results_seen >= 650 && results_seen < 950) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

endmodule
